// ===== rtl/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// shared types for the modular exponentiation block: sequencer states and
// status groups passed between the sequencer, the multiplier and the top
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_t;

  // modular multiplier status
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  // sequencer status toward the handshake logic
  typedef struct packed {
    logic idle;
    logic res_valid;
  } seq_stat_t;

endpackage : modexp_pkg

`default_nettype wire

// ===== rtl/modular_exponentiation_top.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// base ^ exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// channels: in_valid / in_ready take one transaction of base, exponent and
//   modulus; out_valid / out_ready return one out_power_result for each
//   an exponent of zero returns 1, a modulus of one returns 0 otherwise
// sequence: one shared bit-serial multiplier; one multiply reduces the base,
//   then each exponent bit up to the top set bit passes through the step
//   state, a multiply when set and a squaring unless it is the top bit; a
//   zero exponent or zero modulus skips the arithmetic
// throughput: one transaction at a time; in_ready rises once the result has
//   moved to the output register, in the same cycle as out_valid rises
// reset: rst_n is synchronous, active low; it empties the output register and
//   returns the sequencer to idle, any transaction in flight is dropped
// stall: with out_ready low the result holds in the output register; a second
//   finished result waits in the sequencer, and in_ready stays low
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_top
  import modexp_pkg::*;
#(
  parameter int OPERAND_BITS = 63
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [OPERAND_BITS-1:0] in_base,
  input  wire logic [OPERAND_BITS-1:0] in_exponent,
  input  wire logic [OPERAND_BITS-1:0] in_modulus,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [OPERAND_BITS-1:0]      out_power_result
);

  localparam int N = OPERAND_BITS;

  seq_stat_t    seq_stat;
  mm_stat_t     mm_stat;
  logic [N-1:0] seq_result;
  logic         mul_start;
  logic [N-1:0] mul_x;
  logic [N-1:0] mul_y;
  logic [N-1:0] mul_m;
  logic [N-1:0] mul_prod;

  logic         in_accept;
  logic         res_ready;

  logic         out_valid_r;
  logic [N-1:0] out_power_result_r;

  // new transaction only while the sequencer is idle
  assign in_ready  = seq_stat.idle;
  assign in_accept = in_valid && seq_stat.idle;

  // output register takes a result when empty or emptying this cycle
  assign res_ready = !out_valid_r || out_ready;

  modexp_seq #(
    .N(N)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .base     (in_base),
    .exponent (in_exponent),
    .modulus  (in_modulus),
    .res_ready(res_ready),
    .stat     (seq_stat),
    .result   (seq_result),
    .mul_start(mul_start),
    .mul_x    (mul_x),
    .mul_y    (mul_y),
    .mul_m    (mul_m),
    .mul_stat (mm_stat),
    .mul_prod (mul_prod)
  );

  // shared bit-serial modular multiplier
  modexp_mulser #(
    .N(N)
  ) u_mulser (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .x    (mul_x),
    .y    (mul_y),
    .m    (mul_m),
    .stat (mm_stat),
    .prod (mul_prod)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_stat.res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_stat.res_valid && res_ready) begin
      out_power_result_r <= seq_result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_power_result = out_power_result_r;

  // an accepted transaction always leaves the sequencer busy
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !seq_stat.idle)
    else $error("sequencer idle right after accepting a transaction");

  // the multiplier only runs on behalf of a transaction in flight
  a_mul_owned : assert property (@(posedge clk) disable iff (!rst_n)
    (mm_stat.busy || mm_stat.done) |-> !seq_stat.idle)
    else $error("multiplier active while sequencer idle");

  // a finished result moves into the output register
  a_res_moved : assert property (@(posedge clk) disable iff (!rst_n)
    (seq_stat.res_valid && res_ready) |=> (out_valid && !seq_stat.res_valid))
    else $error("result lost between sequencer and output register");

  // a stalled finished result is kept
  a_res_held : assert property (@(posedge clk) disable iff (!rst_n)
    (seq_stat.res_valid && !res_ready) |=> seq_stat.res_valid)
    else $error("sequencer dropped a waiting result");

endmodule : modular_exponentiation_top

`default_nettype wire

// ===== rtl/modexp_mulser.sv =====
// ----------------------------------------------------------------------------
// modexp_mulser
// bit-serial modular multiplier: one multiplier bit per cycle, msb first,
// computes (x * y) mod m for x, y below m
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_mulser
  import modexp_pkg::*;
#(
  parameter int N = 63
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [N-1:0] x,
  input  wire logic [N-1:0] y,
  input  wire logic [N-1:0] m,
  output mm_stat_t          stat,
  output logic      [N-1:0] prod
);

  localparam int CW = $clog2(N);

  logic [N-1:0]  acc_r, acc_nxt;
  logic [N-1:0]  y_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [N+1:0]  t;
  logic [N+1:0]  m1;
  logic [N+1:0]  m2;

  // t = 2*acc + bit*x stays below 3m, so one of two subtractions finishes it
  always_comb begin
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    t  = {1'b0, acc_r, 1'b0} + (y_r[N-1] ? {2'b00, x} : '0);
    if (t >= m2) begin
      acc_nxt = N'(t - m2);
    end else if (t >= m1) begin
      acc_nxt = N'(t - m1);
    end else begin
      acc_nxt = N'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      y_r   <= y;
      cnt_r <= CW'(N - 1);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[N-2:0], 1'b0};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule : modexp_mulser

`default_nettype wire

// ===== rtl/modexp_seq.sv =====
// ----------------------------------------------------------------------------
// modexp_seq
// square-and-multiply sequencer: holds the operands, scans the exponent lsb
// first and issues reduce, multiply and square operations to the multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_seq
  import modexp_pkg::*;
#(
  parameter int N = 63
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic [N-1:0] base,
  input  wire logic [N-1:0] exponent,
  input  wire logic [N-1:0] modulus,
  input  wire logic         res_ready,
  output seq_stat_t         stat,
  output logic      [N-1:0] result,
  output logic              mul_start,
  output logic      [N-1:0] mul_x,
  output logic      [N-1:0] mul_y,
  output logic      [N-1:0] mul_m,
  input  wire mm_stat_t     mul_stat,
  input  wire logic [N-1:0] mul_prod
);

  state_t       state_r, state_nxt;
  logic         start_r, start_nxt;
  logic [N-1:0] b_r;
  logic [N-1:0] e_r;
  logic [N-1:0] m_r;
  logic [N-1:0] acc_r;
  logic [N-1:0] sq_r;

  logic         trivial;
  logic         last_bit;

  // zero exponent or zero modulus needs no arithmetic
  assign trivial  = (exponent == '0) || (modulus == '0);
  assign last_bit = (e_r[N-1:1] == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = trivial ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mul_stat.done) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        state_nxt = e_r[0] ? ST_MUL : ST_SQR;
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          state_nxt = last_bit ? ST_DONE : ST_SQR;
        end
      end
      ST_SQR: begin
        if (mul_stat.done) begin
          state_nxt = ST_STEP;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    start_nxt      = 1'b0;
    stat.idle      = 1'b0;
    stat.res_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        stat.idle = 1'b1;
        start_nxt = accept && !trivial;
      end
      ST_STEP: start_nxt = 1'b1;
      ST_MUL:  start_nxt = mul_stat.done && !last_bit;
      ST_DONE: stat.res_valid = 1'b1;
      default: start_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          b_r <= base;
          e_r <= exponent;
          m_r <= modulus;
          // exponent zero gives 1; otherwise start from 1 mod m, or 0 for a zero modulus
          if (exponent == '0) begin
            acc_r <= N'(1);
          end else if (modulus == '0 || modulus == N'(1)) begin
            acc_r <= '0;
          end else begin
            acc_r <= N'(1);
          end
        end
      end
      ST_REDUCE: begin
        if (mul_stat.done) begin
          sq_r <= mul_prod;
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          acc_r <= mul_prod;
        end
      end
      ST_SQR: begin
        if (mul_stat.done) begin
          sq_r <= mul_prod;
          e_r  <= {1'b0, e_r[N-1:1]};
        end
      end
      default: ;
    endcase
  end

  // operand selection; the multiplier samples y at start, x and m throughout
  always_comb begin
    case (state_r)
      ST_REDUCE: begin
        mul_x = N'(1);
        mul_y = b_r;
      end
      ST_MUL: begin
        mul_x = acc_r;
        mul_y = sq_r;
      end
      default: begin
        mul_x = sq_r;
        mul_y = sq_r;
      end
    endcase
  end

  assign mul_start = start_r;
  assign mul_m     = m_r;
  assign result    = acc_r;

endmodule : modexp_seq

`default_nettype wire
